// ----- src/dpf_pkg.sv -----
package dpf_pkg;

  localparam int MAX_SAMPLES_DEF = 65536;
  localparam int Q_DEPTH         = 4;
  localparam int OUT_W           = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_PAD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_PAD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COMBINE_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_FIRST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LAST  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AP_MIN_GAP   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_AP_MAX_GAP   = 3'd7;

  localparam logic signed [15:0] THRESHOLD_RST    = -16'sd5;
  localparam logic [7:0]         START_PAD_RST    = 8'd2;
  localparam logic [7:0]         END_PAD_RST      = 8'd2;
  localparam logic               COMBINE_MODE_RST = 1'b0;
  localparam logic [15:0]        SEARCH_FIRST_RST = 16'd0;
  localparam logic [15:0]        SEARCH_LAST_RST  = 16'd65535;
  localparam logic [15:0]        AP_MIN_GAP_RST   = 16'd75;
  localparam logic [15:0]        AP_MAX_GAP_RST   = 16'd750;

  typedef struct packed {
    logic signed [15:0] threshold;
    logic [7:0]         start_pad;
    logic [7:0]         end_pad;
    logic               combine_mode;
    logic [15:0]        search_first;
    logic [15:0]        search_last;
    logic [15:0]        ap_min_gap;
    logic [15:0]        ap_max_gap;
  } cfg_t;

  // what one queued item carries besides its indices
  typedef struct packed {
    logic fin0;
    logic fin1;
    logic last;
  } evt_flags_t;

endpackage

// ----- src/dpf_front.sv -----
module dpf_front import dpf_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  localparam int IW = $clog2(MAX_SAMPLES),
  localparam int EW = ((IW > 16) ? IW : 16) + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                accept,
  input  logic signed [15:0]  sample,
  input  logic                last_sample,
  output logic                push,
  output evt_flags_t          flags,
  output logic [IW-1:0]       n_idx,
  output logic [IW-1:0]       s0,
  output logic [EW-1:0]       e0,
  output logic [IW-1:0]       s1,
  output logic [EW-1:0]       e1
);

  localparam logic [IW-1:0] IDX_MAX = IW'(MAX_SAMPLES - 1);

  logic [IW-1:0]        idx_r, idx_nxt;
  logic signed [15:0]   d0_r, d0_nxt, d1_r, d1_nxt;
  logic                 inp_r, inp_nxt;
  logic [IW-1:0]        os_r, os_nxt;

  logic signed [15:0]   thr;
  logic [EW-1:0]        win_lo, win_hi;
  logic [IW-1:0]        ca;
  logic                 n_ge1, n_ge2, in_win_a, in_win_b;
  logic                 above_d0, above_d1, above_v;
  logic                 inp_a, inp_b, fin0;
  logic [IW-1:0]        os_a, os_b;
  logic [EW-1:0]        e0_raw;

  function automatic logic [IW-1:0] sub_pad(input logic [IW-1:0] c, input logic [7:0] pad);
    logic [EW-1:0] ce;
    logic [EW-1:0] pe;
    ce = EW'(c);
    pe = EW'(pad);
    sub_pad = (ce >= pe) ? IW'(ce - pe) : '0;
  endfunction

  assign thr    = cfg.threshold;
  assign win_lo = EW'(cfg.search_first) + EW'(cfg.start_pad);
  assign win_hi = EW'(cfg.search_last);

  always_comb begin
    ca       = idx_r - IW'(1);
    n_ge1    = (idx_r != '0);
    n_ge2    = (idx_r > IW'(1));
    in_win_a = (EW'(ca) >= win_lo) && (EW'(ca) < win_hi);
    in_win_b = (EW'(idx_r) >= win_lo) && (EW'(idx_r) < win_hi);
    above_d0 = d0_r > thr;
    above_d1 = d1_r > thr;
    above_v  = sample > thr;

    // previous sample, now that its successor is known
    inp_a = inp_r;
    os_a  = os_r;
    fin0  = 1'b0;
    if (n_ge1 && in_win_a && !above_d0) begin
      if (!n_ge2 || above_d1) begin
        inp_a = 1'b1;
        os_a  = sub_pad(ca, cfg.start_pad);
      end
      if (above_v) begin
        fin0  = inp_a;
        inp_a = 1'b0;
      end
    end
    e0_raw = EW'(ca) + EW'(cfg.end_pad);
    e0     = (last_sample && (e0_raw > EW'(idx_r))) ? EW'(idx_r) : e0_raw;
    s0     = os_a;

    // final sample: may open, never closes
    inp_b = inp_a;
    os_b  = os_a;
    if (in_win_b && !above_v && (!n_ge1 || above_d0)) begin
      inp_b = 1'b1;
      os_b  = sub_pad(idx_r, cfg.start_pad);
    end
    s1 = os_b;
    e1 = (win_hi < EW'(idx_r)) ? win_hi : EW'(idx_r);

    flags.fin0 = fin0;
    flags.fin1 = last_sample && inp_b;
    flags.last = last_sample;
    n_idx      = idx_r;
    push       = accept && (fin0 || last_sample);

    idx_nxt = idx_r;
    d0_nxt  = d0_r;
    d1_nxt  = d1_r;
    inp_nxt = inp_r;
    os_nxt  = os_r;
    if (accept) begin
      if (last_sample) begin
        idx_nxt = '0;
        d0_nxt  = '0;
        d1_nxt  = '0;
        inp_nxt = 1'b0;
        os_nxt  = '0;
      end else begin
        idx_nxt = (idx_r < IDX_MAX) ? idx_r + IW'(1) : idx_r;
        d1_nxt  = d0_r;
        d0_nxt  = sample;
        inp_nxt = inp_a;
        os_nxt  = os_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      d0_r  <= '0;
      d1_r  <= '0;
      inp_r <= 1'b0;
      os_r  <= '0;
    end else begin
      idx_r <= idx_nxt;
      d0_r  <= d0_nxt;
      d1_r  <= d1_nxt;
      inp_r <= inp_nxt;
      os_r  <= os_nxt;
    end
  end

endmodule

// ----- src/dpf_queue.sv -----
module dpf_queue import dpf_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = Q_DEPTH,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- src/dpf_back.sv -----
module dpf_back import dpf_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  localparam int IW = $clog2(MAX_SAMPLES),
  localparam int EW = ((IW > 16) ? IW : 16) + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             q_valid,
  input  evt_flags_t       flags,
  input  logic [IW-1:0]    n_idx,
  input  logic [IW-1:0]    s0,
  input  logic [EW-1:0]    e0,
  input  logic [IW-1:0]    s1,
  input  logic [EW-1:0]    e1,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_has_pulse,
  output logic [OUT_W-1:0] out_pulse_start,
  output logic [OUT_W-1:0] out_pulse_end,
  output logic             out_record_end
);

  typedef enum logic [1:0] {PH_F0, PH_F1, PH_END} phase_t;

  phase_t            ph_r, ph_nxt;
  logic              hv_r, hv_nxt;
  logic [IW-1:0]     hs_r, hs_nxt;
  logic [EW-1:0]     he_r, he_nxt;
  logic [EW-1:0]     pre_r, pre_nxt;
  logic              ov_r, ov_nxt;
  logic              has_r, rec_r;
  logic [OUT_W-1:0]  ps_r, pe_r;

  logic              step, use0, use1, use_end, more, drop;
  logic [IW-1:0]     fs;
  logic [EW-1:0]     fe, fs_e, hs_e, he_c, pre_c, cut, n_e;
  logic              em, em_has, em_rec;
  logic [OUT_W-1:0]  em_start, em_end;

  always_comb begin
    step    = q_valid && (!ov_r || !out_stall);
    use0    = (ph_r == PH_F0) && flags.fin0;
    use1    = !use0 && (ph_r != PH_END) && flags.fin1;
    use_end = !use0 && !use1 && flags.last;
    fs      = use0 ? s0 : s1;
    fe      = use0 ? e0 : e1;
    fs_e    = EW'(fs);
    hs_e    = EW'(hs_r);
    n_e     = EW'(n_idx);
    he_c    = (flags.last && (he_r > n_e)) ? n_e : he_r;
    pre_c   = (flags.last && (pre_r > n_e)) ? n_e : pre_r;
    cut     = (fs_e < he_c) ? fs_e : he_c;
    drop    = hv_r && (fs_e > hs_e + EW'(cfg.ap_min_gap)) &&
              (fs_e < hs_e + EW'(cfg.ap_max_gap));

    hv_nxt   = hv_r;
    hs_nxt   = hs_r;
    he_nxt   = he_r;
    pre_nxt  = pre_r;
    em       = 1'b0;
    em_has   = 1'b0;
    em_rec   = 1'b0;
    em_start = '0;
    em_end   = '0;
    more     = 1'b0;

    if (step) begin
      he_nxt  = he_c;
      pre_nxt = pre_c;
      if (use0 || use1) begin
        more = use0 ? (flags.fin1 || flags.last) : flags.last;
        if (cfg.combine_mode) begin
          if (hv_r && (fs_e < pre_c)) begin
            he_nxt = fe;
          end else begin
            em       = hv_r;
            em_has   = 1'b1;
            em_start = OUT_W'(hs_r);
            em_end   = OUT_W'(he_c);
            hv_nxt   = 1'b1;
            hs_nxt   = fs;
            he_nxt   = fe;
          end
          pre_nxt = fe;
        end else if (!drop) begin
          em       = hv_r && !(cut < hs_e);
          em_has   = 1'b1;
          em_start = OUT_W'(hs_r);
          em_end   = OUT_W'(cut);
          hv_nxt   = 1'b1;
          hs_nxt   = fs;
          he_nxt   = fe;
          pre_nxt  = fe;
        end
      end else if (use_end) begin
        em     = 1'b1;
        em_rec = 1'b1;
        if (hv_r && !(!cfg.combine_mode && (he_c < hs_e))) begin
          em_has   = 1'b1;
          em_start = OUT_W'(hs_r);
          em_end   = OUT_W'(he_c);
        end
        hv_nxt  = 1'b0;
        hs_nxt  = '0;
        he_nxt  = '0;
        pre_nxt = '0;
      end
    end

    q_pop = step && !more;
    if (!step) begin
      ph_nxt = ph_r;
    end else if (!more) begin
      ph_nxt = PH_F0;
    end else if (use0) begin
      ph_nxt = PH_F1;
    end else begin
      ph_nxt = PH_END;
    end

    if (step) begin
      ov_nxt = em;
    end else begin
      ov_nxt = ov_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_F0;
      hv_r  <= 1'b0;
      hs_r  <= '0;
      he_r  <= '0;
      pre_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      ph_r  <= ph_nxt;
      hv_r  <= hv_nxt;
      hs_r  <= hs_nxt;
      he_r  <= he_nxt;
      pre_r <= pre_nxt;
      ov_r  <= ov_nxt;
    end
    if (step && em) begin
      has_r <= em_has;
      ps_r  <= em_start;
      pe_r  <= em_end;
      rec_r <= em_rec;
    end
  end

  assign out_valid       = ov_r;
  assign out_has_pulse   = has_r;
  assign out_pulse_start = ps_r;
  assign out_pulse_end   = pe_r;
  assign out_record_end  = rec_r;

endmodule

// ----- src/discriminator_pulse_finder.sv -----
// Channel  Ports                                         Accepted when
// in       in_valid/in_stall, in_sample, in_last_sample  in_valid && !in_stall
// out      out_valid/out_stall, out_has_pulse,           out_valid && !out_stall
//          out_pulse_start, out_pulse_end, out_record_end
// cfg      cfg_we, cfg_index, cfg_data                   cfg_we
//
// One sample per cycle in while in_stall is low; the front classifies a sample once its
// successor is accepted, the final one in its own accept cycle. Finished pulses and record
// ends go through a 4-entry queue to the back end, which takes one step per cycle unless a
// held result stalls it: one step for a pulse item, one to three for a record-end item.
// An item gives zero to three registered results. in_stall rises only when the queue is full.
// rst_n is synchronous; it clears the record state and loads register defaults.
module discriminator_pulse_finder import dpf_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [15:0]    in_sample,
  input  logic                  in_last_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_has_pulse,
  output logic [OUT_W-1:0]      out_pulse_start,
  output logic [OUT_W-1:0]      out_pulse_end,
  output logic                  out_record_end,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int EW = ((IW > 16) ? IW : 16) + 1;
  localparam int QW = $bits(evt_flags_t) + 3 * IW + 2 * EW;

  cfg_t           cfg_r, cfg_nxt;
  logic           accept, push, q_pop, q_full, q_empty;
  evt_flags_t     f_flags, b_flags;
  logic [IW-1:0]  f_n, f_s0, f_s1, b_n, b_s0, b_s1;
  logic [EW-1:0]  f_e0, f_e1, b_e0, b_e1;
  logic [QW-1:0]  q_din, q_dout;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD:    cfg_nxt.threshold    = cfg_data;
        REG_START_PAD:    cfg_nxt.start_pad    = cfg_data[7:0];
        REG_END_PAD:      cfg_nxt.end_pad      = cfg_data[7:0];
        REG_COMBINE_MODE: cfg_nxt.combine_mode = cfg_data[0];
        REG_SEARCH_FIRST: cfg_nxt.search_first = cfg_data;
        REG_SEARCH_LAST:  cfg_nxt.search_last  = cfg_data;
        REG_AP_MIN_GAP:   cfg_nxt.ap_min_gap   = cfg_data;
        REG_AP_MAX_GAP:   cfg_nxt.ap_max_gap   = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold    <= THRESHOLD_RST;
      cfg_r.start_pad    <= START_PAD_RST;
      cfg_r.end_pad      <= END_PAD_RST;
      cfg_r.combine_mode <= COMBINE_MODE_RST;
      cfg_r.search_first <= SEARCH_FIRST_RST;
      cfg_r.search_last  <= SEARCH_LAST_RST;
      cfg_r.ap_min_gap   <= AP_MIN_GAP_RST;
      cfg_r.ap_max_gap   <= AP_MAX_GAP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  dpf_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (accept),
    .sample      (in_sample),
    .last_sample (in_last_sample),
    .push        (push),
    .flags       (f_flags),
    .n_idx       (f_n),
    .s0          (f_s0),
    .e0          (f_e0),
    .s1          (f_s1),
    .e1          (f_e1)
  );

  assign q_din = {f_flags, f_n, f_s0, f_e0, f_s1, f_e1};
  assign {b_flags, b_n, b_s0, b_e0, b_s1, b_e1} = q_dout;

  dpf_queue #(.W(QW), .DEPTH(Q_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  dpf_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (!q_empty),
    .flags           (b_flags),
    .n_idx           (b_n),
    .s0              (b_s0),
    .e0              (b_e0),
    .s1              (b_s1),
    .e1              (b_e1),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_has_pulse   (out_has_pulse),
    .out_pulse_start (out_pulse_start),
    .out_pulse_end   (out_pulse_end),
    .out_record_end  (out_record_end)
  );

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  a_last_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_sample) |=> !q_empty)
    else $error("record end item not queued");

  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_pulse) |-> (out_record_end && out_pulse_start == '0 &&
                                       out_pulse_end == '0))
    else $error("empty result that is not a record end");

endmodule

// ----- dv/pulse_checker.sv -----
module pulse_checker import dpf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic signed [15:0]    in_sample,
  input  logic                  in_last_sample,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_has_pulse,
  input  logic [OUT_W-1:0]      out_pulse_start,
  input  logic [OUT_W-1:0]      out_pulse_end,
  input  logic                  out_record_end,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic             has_pulse;
    logic [OUT_W-1:0] pulse_start;
    logic [OUT_W-1:0] pulse_end;
    logic             record_end;
  } pulse_result_t;

  pulse_result_t awaited_pulses[$];

  // register copies
  logic signed [15:0] thr;
  logic [7:0]         pad_before;
  logic [7:0]         pad_after;
  logic               merge_mode;
  logic [15:0]        win_first;
  logic [15:0]        win_last;
  logic [15:0]        gap_lo;
  logic [15:0]        gap_hi;

  // record state
  int unsigned        sample_no;
  logic signed [15:0] prev0;
  logic signed [15:0] prev1;
  bit                 pulse_open;
  int unsigned        open_at;
  bit                 held;
  int unsigned        held_s;
  int unsigned        held_e;
  int unsigned        raw_end;

  function automatic void clear_record();
    sample_no  = 0;
    prev0      = '0;
    prev1      = '0;
    pulse_open = 1'b0;
    open_at    = 0;
    held       = 1'b0;
    held_s     = 0;
    held_e     = 0;
    raw_end    = 0;
  endfunction

  function automatic void expect_pulse(bit has, int unsigned s, int unsigned e, bit rec);
    pulse_result_t p;
    p.has_pulse   = has;
    p.pulse_start = s[OUT_W-1:0];
    p.pulse_end   = e[OUT_W-1:0];
    p.record_end  = rec;
    awaited_pulses.insert(awaited_pulses.size(), p);
  endfunction

  // a finished pulse meets the held one
  function automatic void close_pulse(int unsigned s, int unsigned e);
    if (merge_mode) begin
      if (held && s < raw_end) begin
        held_e = e;
      end else begin
        if (held) expect_pulse(1'b1, held_s, held_e, 1'b0);
        held   = 1'b1;
        held_s = s;
        held_e = e;
      end
    end else begin
      if (held && s > held_s + gap_lo && s < held_s + gap_hi) return;
      if (held) begin
        if (s < held_e) held_e = s;
        if (!(held_e < held_s)) expect_pulse(1'b1, held_s, held_e, 1'b0);
      end
      held   = 1'b1;
      held_s = s;
      held_e = e;
    end
    raw_end = e;
  endfunction

  function automatic void judge_index(int unsigned c, logic signed [15:0] v, bit pred_above,
                                      bit succ_known, bit succ_above, int unsigned lim);
    int unsigned e;
    if (c < win_first + pad_before || c >= win_last) return;
    if (v > thr) return;
    if (pred_above) begin
      pulse_open = 1'b1;
      open_at    = (c >= pad_before) ? c - pad_before : 0;
    end
    if (succ_known && succ_above) begin
      if (pulse_open) begin
        e = c + pad_after;
        if (e > lim) e = lim;
        close_pulse(open_at, e);
      end
      pulse_open = 1'b0;
    end
  endfunction

  function automatic void track_sample(logic signed [15:0] v, bit last);
    int unsigned n;
    int unsigned lim;
    int unsigned e;
    n   = sample_no;
    lim = 32'hFFFF_FFFF;
    if (last) begin
      lim = n;
      if (held_e > n) held_e = n;
      if (raw_end > n) raw_end = n;
    end
    if (n >= 1) judge_index(n - 1, prev0, (n >= 2) ? (prev1 > thr) : 1'b1, 1'b1, v > thr, lim);
    if (last) begin
      judge_index(n, v, (n >= 1) ? (prev0 > thr) : 1'b1, 1'b0, 1'b0, lim);
      if (pulse_open) begin
        e = (win_last < n) ? win_last : n;
        close_pulse(open_at, e);
        pulse_open = 1'b0;
      end
      if (held) begin
        if (held_e > n) held_e = n;
        if (!merge_mode && held_e < held_s) expect_pulse(1'b0, 0, 0, 1'b1);
        else expect_pulse(1'b1, held_s, held_e, 1'b1);
      end else begin
        expect_pulse(1'b0, 0, 0, 1'b1);
      end
      clear_record();
    end else begin
      prev1 = prev0;
      prev0 = v;
      if (sample_no < MAX_SAMPLES_DEF - 1) sample_no++;
    end
  endfunction

  always @(posedge clk) begin
    pulse_result_t got;
    pulse_result_t want;
    if (!rst_n) begin
      thr        = THRESHOLD_RST;
      pad_before = START_PAD_RST;
      pad_after  = END_PAD_RST;
      merge_mode = COMBINE_MODE_RST;
      win_first  = SEARCH_FIRST_RST;
      win_last   = SEARCH_LAST_RST;
      gap_lo     = AP_MIN_GAP_RST;
      gap_hi     = AP_MAX_GAP_RST;
      clear_record();
      awaited_pulses.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD:    thr        = $signed(cfg_data);
          REG_START_PAD:    pad_before = cfg_data[7:0];
          REG_END_PAD:      pad_after  = cfg_data[7:0];
          REG_COMBINE_MODE: merge_mode = cfg_data[0];
          REG_SEARCH_FIRST: win_first  = cfg_data;
          REG_SEARCH_LAST:  win_last   = cfg_data;
          REG_AP_MIN_GAP:   gap_lo     = cfg_data;
          REG_AP_MAX_GAP:   gap_hi     = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) track_sample(in_sample, in_last_sample);
      if (out_valid && !out_stall) begin
        got.has_pulse   = out_has_pulse;
        got.pulse_start = out_pulse_start;
        got.pulse_end   = out_pulse_end;
        got.record_end  = out_record_end;
        if (awaited_pulses.size() == 0) begin
          $display("%0t: unexpected result has=%0d start=%0d end=%0d rec_end=%0d", $time,
                   got.has_pulse, got.pulse_start, got.pulse_end, got.record_end);
          fail_count++;
        end else begin
          want = awaited_pulses.pop_front();
          if (got !== want) begin
            $display("%0t: expected has=%0d s=%0d e=%0d rec=%0d, got has=%0d s=%0d e=%0d rec=%0d",
                     $time, want.has_pulse, want.pulse_start, want.pulse_end, want.record_end,
                     got.has_pulse, got.pulse_start, got.pulse_end, got.record_end);
            fail_count++;
          end
        end
      end
    end
    pending = awaited_pulses.size();
  end

endmodule

// ----- dv/testbench.sv -----
module testbench import dpf_pkg::*;;

  localparam int RANDOM_ITEMS   = 750;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_CYCLES   = 16;

  typedef enum {REC_SHAPED, REC_NOISE, REC_DENSE} rec_kind_t;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic signed [15:0]    in_sample      = '0;
  logic                  in_last_sample = 1'b0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic                  out_has_pulse;
  logic [OUT_W-1:0]      out_pulse_start;
  logic [OUT_W-1:0]      out_pulse_end;
  logic                  out_record_end;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  int fail_count;
  int pending;
  int cycles     = 0;
  int sent_items = 0;
  int gap_pct    = 0;
  int thr_now    = -5;
  int quiet_at   = 32'h7fff_ffff;
  bit squeeze_req = 1'b0;

  discriminator_pulse_finder u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_last_sample (in_last_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_has_pulse  (out_has_pulse),
    .out_pulse_start(out_pulse_start),
    .out_pulse_end  (out_pulse_end),
    .out_record_end (out_record_end),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  pulse_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_last_sample (in_last_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_has_pulse  (out_has_pulse),
    .out_pulse_start(out_pulse_start),
    .out_pulse_end  (out_pulse_end),
    .out_record_end (out_record_end),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic signed [15:0] clip(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic int above_level();
    return thr_now + 1 + (($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 3000))
                                                       : int'($urandom_range(0, 20)));
  endfunction

  function automatic int below_level();
    return thr_now - (($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 3000))
                                                  : int'($urandom_range(0, 20)));
  endfunction

  function automatic int noise_level();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic send_sample(input int value, input bit last);
    if (sent_items >= quiet_at) gap_pct = 0;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample      <= clip(value);
    in_last_sample <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_record(input int len, input rec_kind_t kind);
    int below_left;
    int v;
    below_left = 0;
    for (int k = 0; k < len; k++) begin
      case (kind)
        REC_NOISE: v = noise_level();
        REC_DENSE: v = (k % 3 == 0) ? above_level() : below_level();
        default: begin
          if (below_left > 0) begin
            v = below_level();
            below_left--;
          end else if ($urandom_range(0, 5) == 0) begin
            v = below_level();
            below_left = $urandom_range(0, 5);
          end else if ($urandom_range(0, 19) == 0) begin
            v = noise_level();
          end else begin
            v = above_level();
          end
        end
      endcase
      send_sample(v, k == len - 1);
    end
  endtask

  // wait until the block is idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int thr, input int sp, input int ep, input int comb,
                            input int sf, input int sl, input int mn, input int mx);
    logic [CFG_DATA_W-1:0] vals [1 << CFG_IDX_W];
    vals[REG_THRESHOLD]    = thr[15:0];
    vals[REG_START_PAD]    = CFG_DATA_W'(sp[7:0]);
    vals[REG_END_PAD]      = CFG_DATA_W'(ep[7:0]);
    vals[REG_COMBINE_MODE] = CFG_DATA_W'(comb[0]);
    vals[REG_SEARCH_FIRST] = sf[15:0];
    vals[REG_SEARCH_LAST]  = sl[15:0];
    vals[REG_AP_MIN_GAP]   = mn[15:0];
    vals[REG_AP_MAX_GAP]   = mx[15:0];
    thr_now = int'($signed(thr[15:0]));
    cfg_we <= 1'b1;
    for (int r = 0; r < (1 << CFG_IDX_W); r++) begin
      cfg_index <= r[CFG_IDX_W-1:0];
      cfg_data  <= vals[r];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    int thr;
    int sp;
    int ep;
    int sf;
    int sl;
    int mn;
    int mx;
    case ($urandom_range(0, 9))
      0:       thr = noise_level();
      1:       thr = 32767;
      2:       thr = -32768;
      default: thr = -int'($urandom_range(0, 400));
    endcase
    sp = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255)) : int'($urandom_range(0, 6));
    ep = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255)) : int'($urandom_range(0, 6));
    sf = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 65535)) : int'($urandom_range(0, 10));
    case ($urandom_range(0, 5))
      0:       sl = $urandom_range(0, 65535);
      1, 2:    sl = $urandom_range(10, 80);
      default: sl = 65535;
    endcase
    mn = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 65535)) : int'($urandom_range(0, 15));
    mx = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 65535))
                                     : mn + int'($urandom_range(0, 40));
    set_config(thr, sp, ep, $urandom_range(0, 1), sf, sl, mn, mx);
  endtask

  initial begin
    int base;
    int phase;
    int len;
    rec_kind_t kind;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: single-sample records, extremes, exact threshold, start clamp
    send_sample(-100, 1'b1);
    send_sample(100, 1'b1);
    send_sample(32767, 1'b0);
    send_sample(-32768, 1'b0);
    send_sample(-5, 1'b0);
    send_sample(-4, 1'b0);
    send_sample(-5, 1'b0);
    send_sample(32767, 1'b0);
    send_sample(-32768, 1'b0);
    send_sample(-32768, 1'b1);
    settle();
    // everything inside, widest pads, merging
    set_config(32767, 255, 255, 1, 0, 65535, 65535, 65535);
    send_record(6, REC_NOISE);
    settle();
    // empty search window
    set_config(-32768, 0, 0, 0, 65535, 0, 0, 0);
    send_record(6, REC_NOISE);
    settle();
    // lowest threshold over the full window
    set_config(-32768, 0, 0, 0, 0, 65535, 0, 0);
    send_sample(0, 1'b0);
    send_sample(-32768, 1'b0);
    send_sample(-32768, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-32768, 1'b1);
    settle();

    base     = sent_items;
    quiet_at = base + RANDOM_ITEMS - 120;
    phase    = 0;
    while (sent_items - base < RANDOM_ITEMS) begin
      if (sent_items - base > RANDOM_ITEMS - 120) begin
        gap_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       gap_pct = 0;
          1:       gap_pct = 10;
          default: gap_pct = 30;
        endcase
      end
      if (phase == 1) begin
        // output held off while dense pulses keep coming
        set_config(-5, 0, 0, 0, 0, 65535, 0, 0);
        gap_pct = 0;
        squeeze_req = 1'b1;
        send_record(80, REC_DENSE);
      end else begin
        random_config();
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 9))
            0:       len = $urandom_range(1, 3);
            1:       len = $urandom_range(60, 120);
            default: len = $urandom_range(4, 40);
          endcase
          case ($urandom_range(0, 9))
            0:       kind = REC_NOISE;
            1:       kind = REC_DENSE;
            default: kind = REC_SHAPED;
          endcase
          send_record(len, kind);
        end
      end
      settle();
      phase++;
    end

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/dpf_pkg.sv
src/dpf_front.sv
src/dpf_queue.sv
src/dpf_back.sv
src/discriminator_pulse_finder.sv
dv/pulse_checker.sv
dv/testbench.sv
